FILE: design/rba_pkg.sv
`timescale 1ns / 1ps

package rba_pkg;

  localparam int TIME_W   = 32;
  localparam int FINISH_W = 48;
  localparam int COUNT_W  = 32;
  localparam int ROOM_W   = 4;
  localparam int CFG_W    = 5;

  localparam logic [FINISH_W-1:0] FINISH_MAX  = {FINISH_W{1'b1}};
  localparam logic [COUNT_W-1:0]  COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CFG_W-1:0]    ROOMS_RESET = 5'd16;

  localparam logic ACT_BOOK  = 1'b0;
  localparam logic ACT_CLEAR = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_COMMIT,
    ST_CLEAR,
    ST_RESULT
  } rba_state_e;

  typedef struct packed {
    logic load;        // latch request, restart the scan
    logic scan_issue;  // read the next room entry
    logic commit;      // update the picked room and the busiest tracker
    logic clear;       // drop every room and the busiest tracker
    logic out_load;    // move the result into the output register
  } rba_cmd_t;

  typedef struct packed {
    logic scan_last;   // the read being issued is for the last room in use
  } rba_stat_t;

endpackage

FILE: design/room_booking_allocator_core.sv
`timescale 1ns / 1ps
// Room booking allocator.
// Input channel (in_valid_i / in_stall_o) carries one request: a booking
// (action 0, start and end time) or a clear of every room (action 1).
// Output channel (out_valid_o / out_stall_i) returns one result per request:
// assigned room, actual finish time, delayed flag and the busiest room with
// its booking count. The config channel (cfg_valid_i / cfg_ready_o) writes
// the number of rooms in use; write it only while no request is in flight.
// A booking reads the room store one entry per cycle over the N rooms in
// use (zero counts as one, capped at MAX_ROOMS), then drains the last read,
// commits and loads the result; a clear goes from its clear step straight
// to loading the result. The next request is taken the cycle after the
// result enters the output register.
// The output register holds a result while out_stall_i is high; the next
// request may still be accepted and worked on meanwhile, and its result
// waits until the register frees.
// Reset empties every room, zeroes the busiest tracker and sets the room
// count to 16; no clearing pass is needed.

module room_booking_allocator_core #(
  parameter int MAX_ROOMS = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [rba_pkg::CFG_W-1:0]      cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           in_action_i,
  input  logic [rba_pkg::TIME_W-1:0]     in_start_time_i,
  input  logic [rba_pkg::TIME_W-1:0]     in_end_time_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [rba_pkg::ROOM_W-1:0]     out_assigned_room_o,
  output logic [rba_pkg::FINISH_W-1:0]   out_finish_time_o,
  output logic                           out_delayed_o,
  output logic [rba_pkg::ROOM_W-1:0]     out_busiest_room_o,
  output logic [rba_pkg::COUNT_W-1:0]    out_busiest_count_o
);

  logic [rba_pkg::CFG_W-1:0] room_count_q;
  rba_pkg::rba_cmd_t         cmd;
  rba_pkg::rba_stat_t        stat;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      room_count_q <= rba_pkg::ROOMS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      room_count_q <= cfg_data_i;
    end
  end

  rba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_action_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  rba_datapath #(
    .MAX_ROOMS (MAX_ROOMS)
  ) u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .stat_o              (stat),
    .room_count_i        (room_count_q),
    .in_start_time_i     (in_start_time_i),
    .in_end_time_i       (in_end_time_i),
    .out_assigned_room_o (out_assigned_room_o),
    .out_finish_time_o   (out_finish_time_o),
    .out_delayed_o       (out_delayed_o),
    .out_busiest_room_o  (out_busiest_room_o),
    .out_busiest_count_o (out_busiest_count_o)
  );

endmodule

FILE: design/rba_ctrl.sv
`timescale 1ns / 1ps

module rba_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_action_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rba_pkg::rba_stat_t stat_i,
  output rba_pkg::rba_cmd_t  cmd_o
);

  rba_pkg::rba_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rba_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      rba_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = (in_action_i == rba_pkg::ACT_CLEAR) ? rba_pkg::ST_CLEAR
                                                           : rba_pkg::ST_SCAN;
        end
      end
      rba_pkg::ST_SCAN: begin
        cmd_o.scan_issue = 1'b1;
        if (stat_i.scan_last) begin
          state_d = rba_pkg::ST_DRAIN;
        end
      end
      rba_pkg::ST_DRAIN: begin
        state_d = rba_pkg::ST_COMMIT;
      end
      rba_pkg::ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = rba_pkg::ST_RESULT;
      end
      rba_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = rba_pkg::ST_RESULT;
      end
      rba_pkg::ST_RESULT: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = rba_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = rba_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: design/rba_datapath.sv
`timescale 1ns / 1ps

module rba_datapath #(
  parameter int MAX_ROOMS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rba_pkg::rba_cmd_t               cmd_i,
  output rba_pkg::rba_stat_t              stat_o,
  input  logic [rba_pkg::CFG_W-1:0]       room_count_i,
  input  logic [rba_pkg::TIME_W-1:0]      in_start_time_i,
  input  logic [rba_pkg::TIME_W-1:0]      in_end_time_i,
  output logic [rba_pkg::ROOM_W-1:0]      out_assigned_room_o,
  output logic [rba_pkg::FINISH_W-1:0]    out_finish_time_o,
  output logic                            out_delayed_o,
  output logic [rba_pkg::ROOM_W-1:0]      out_busiest_room_o,
  output logic [rba_pkg::COUNT_W-1:0]     out_busiest_count_o
);

  localparam int IDX_W = (MAX_ROOMS > 1) ? $clog2(MAX_ROOMS) : 1;
  localparam int FW    = rba_pkg::FINISH_W;
  localparam int CW    = rba_pkg::COUNT_W;
  localparam int TW    = rba_pkg::TIME_W;
  localparam int RW    = rba_pkg::ROOM_W;

  // Room store: one read port used by the scan, one write port used at commit.
  logic [FW-1:0]        fin_mem [MAX_ROOMS];
  logic [CW-1:0]        cnt_mem [MAX_ROOMS];
  logic [MAX_ROOMS-1:0] valid_q;

  logic [TW-1:0]    start_q, end_q;
  logic [IDX_W-1:0] scan_addr_q, last_idx;
  logic [IDX_W-1:0] rd_addr_q;
  logic [FW-1:0]    rd_fin_q;
  logic [CW-1:0]    rd_cnt_q;
  logic             rd_vld_q, rd_pend_q;

  logic             found_q;
  logic [IDX_W-1:0] free_idx_q, min_idx_q;
  logic [CW-1:0]    free_cnt_q, min_cnt_q;
  logic [FW-1:0]    min_fin_q;

  logic [CW-1:0]    best_cnt_q;
  logic [IDX_W-1:0] best_room_q;

  logic [RW-1:0]    res_room_q, res_busy_room_q;
  logic [FW-1:0]    res_fin_q;
  logic             res_late_q;
  logic [CW-1:0]    res_busy_cnt_q;

  logic [FW-1:0]    fin_e;
  logic [CW-1:0]    cnt_e;
  logic [IDX_W-1:0] pick;
  logic [CW-1:0]    cnt_sel, cnt_new;
  logic [TW-1:0]    dur;
  logic [FW:0]      late_sum;
  logic [FW-1:0]    fin_new;
  logic             take_best;
  logic [CW-1:0]    best_cnt_nx;
  logic [IDX_W-1:0] best_room_nx;

  // A count of zero means one room; counts above the store size are capped.
  always_comb begin
    if (room_count_i == '0) begin
      last_idx = '0;
    end else if (32'(room_count_i) > 32'(MAX_ROOMS)) begin
      last_idx = IDX_W'(MAX_ROOMS - 1);
    end else begin
      last_idx = IDX_W'(room_count_i - 5'd1);
    end
  end

  assign stat_o.scan_last = (scan_addr_q == last_idx);

  // Entries never written since the last clear read as zero.
  assign fin_e = rd_vld_q ? rd_fin_q : '0;
  assign cnt_e = rd_vld_q ? rd_cnt_q : '0;

  always_comb begin
    pick     = found_q ? free_idx_q : min_idx_q;
    cnt_sel  = found_q ? free_cnt_q : min_cnt_q;
    dur      = (end_q > start_q) ? (end_q - start_q) : '0;
    late_sum = {1'b0, min_fin_q} + (FW + 1)'(dur);
    if (found_q) begin
      fin_new = FW'(end_q);
    end else if (late_sum[FW]) begin
      fin_new = rba_pkg::FINISH_MAX;
    end else begin
      fin_new = late_sum[FW-1:0];
    end
    cnt_new   = (cnt_sel == rba_pkg::COUNT_MAX) ? cnt_sel : cnt_sel + 1'b1;
    take_best = (cnt_new > best_cnt_q) ||
                ((cnt_new == best_cnt_q) && (pick < best_room_q));
    best_cnt_nx  = take_best ? cnt_new : best_cnt_q;
    best_room_nx = take_best ? pick : best_room_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      fin_mem[pick] <= fin_new;
      cnt_mem[pick] <= cnt_new;
    end
    rd_fin_q  <= fin_mem[scan_addr_q];
    rd_cnt_q  <= cnt_mem[scan_addr_q];
    rd_addr_q <= scan_addr_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      rd_vld_q    <= 1'b0;
      rd_pend_q   <= 1'b0;
      best_cnt_q  <= '0;
      best_room_q <= '0;
    end else begin
      rd_vld_q  <= valid_q[scan_addr_q];
      rd_pend_q <= cmd_i.scan_issue;
      if (cmd_i.clear) begin
        valid_q     <= '0;
        best_cnt_q  <= '0;
        best_room_q <= '0;
      end else if (cmd_i.commit) begin
        valid_q[pick] <= 1'b1;
        best_cnt_q    <= best_cnt_nx;
        best_room_q   <= best_room_nx;
      end
    end
  end

  // Scan: first free room and earliest-finishing room in one pass.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      start_q     <= in_start_time_i;
      end_q       <= in_end_time_i;
      scan_addr_q <= '0;
      found_q     <= 1'b0;
    end else begin
      if (cmd_i.scan_issue) begin
        scan_addr_q <= scan_addr_q + 1'b1;
      end
      if (rd_pend_q) begin
        if (!found_q && (fin_e <= FW'(start_q))) begin
          found_q    <= 1'b1;
          free_idx_q <= rd_addr_q;
          free_cnt_q <= cnt_e;
        end
        if ((rd_addr_q == '0) || (fin_e < min_fin_q)) begin
          min_idx_q <= rd_addr_q;
          min_fin_q <= fin_e;
          min_cnt_q <= cnt_e;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clear) begin
      res_room_q      <= '0;
      res_fin_q       <= '0;
      res_late_q      <= 1'b0;
      res_busy_room_q <= '0;
      res_busy_cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      res_room_q      <= RW'(pick);
      res_fin_q       <= fin_new;
      res_late_q      <= !found_q;
      res_busy_room_q <= RW'(best_room_nx);
      res_busy_cnt_q  <= best_cnt_nx;
    end
    if (cmd_i.out_load) begin
      out_assigned_room_o <= res_room_q;
      out_finish_time_o   <= res_fin_q;
      out_delayed_o       <= res_late_q;
      out_busiest_room_o  <= res_busy_room_q;
      out_busiest_count_o <= res_busy_cnt_q;
    end
  end

endmodule

FILE: design/rba_checker.sv
`timescale 1ns / 1ps

module rba_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_stall_o,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [rba_pkg::ROOM_W-1:0]   out_assigned_room_o,
  input logic [rba_pkg::FINISH_W-1:0] out_finish_time_o,
  input logic                         out_delayed_o,
  input logic [rba_pkg::COUNT_W-1:0]  out_busiest_count_o
);

  // A held result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A held result keeps its finish time.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_finish_time_o))
    else $error("stalled result changed");

  // One request at a time: after acceptance the input stalls.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request accepted while another is in progress");

  // A delayed meeting waits for a busy room, so it cannot finish at zero.
  a_delay_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_delayed_o |-> out_finish_time_o != '0)
    else $error("delayed meeting with zero finish time");

  // Any booking leaves a busiest count of at least one; zero marks a clear.
  a_clear_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_busiest_count_o == '0) |->
      (out_assigned_room_o == '0) && (out_finish_time_o == '0) && !out_delayed_o)
    else $error("clear result with nonzero fields");

endmodule

bind room_booking_allocator_core rba_checker u_rba_checker (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ROOMS          = 16;
  localparam int IDLE_PCT       = 24;
  localparam int SETTLE         = 24;
  localparam int HOLD_CYCLES    = 300;
  localparam int STALL_LIMIT    = 2000;
  localparam int PHASE_ITEMS    = 140;
  localparam int CHAIN_BOOKINGS = 24;

  typedef struct packed {
    logic [rba_pkg::ROOM_W-1:0]   room;
    logic [rba_pkg::FINISH_W-1:0] finish;
    logic                         delayed;
    logic [rba_pkg::ROOM_W-1:0]   busiest_room;
    logic [rba_pkg::COUNT_W-1:0]  busiest_count;
  } allocation_t;

  logic                         clk = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [rba_pkg::CFG_W-1:0]    cfg_data_i = '0;
  logic                         in_valid_i = 1'b0;
  logic                         in_stall_o;
  logic                         in_action_i = rba_pkg::ACT_BOOK;
  logic [rba_pkg::TIME_W-1:0]   in_start_time_i = '0;
  logic [rba_pkg::TIME_W-1:0]   in_end_time_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i = 1'b0;
  logic [rba_pkg::ROOM_W-1:0]   out_assigned_room_o;
  logic [rba_pkg::FINISH_W-1:0] out_finish_time_o;
  logic                         out_delayed_o;
  logic [rba_pkg::ROOM_W-1:0]   out_busiest_room_o;
  logic [rba_pkg::COUNT_W-1:0]  out_busiest_count_o;

  // Mirror of the room store, kept in request acceptance order.
  logic [rba_pkg::FINISH_W-1:0] room_free_at [ROOMS] = '{default: '0};
  logic [rba_pkg::COUNT_W-1:0]  room_bookings [ROOMS] = '{default: '0};
  logic [rba_pkg::COUNT_W-1:0]  top_count = '0;
  logic [rba_pkg::ROOM_W-1:0]   top_room = '0;
  logic [rba_pkg::CFG_W-1:0]    rooms_cfg = rba_pkg::ROOMS_RESET;

  allocation_t allocations [$];
  int          errors = 0;
  int          in_idle_pct = IDLE_PCT;
  int          out_idle_pct = IDLE_PCT;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          quiet_cycles = 0;

  room_booking_allocator_core #(
    .MAX_ROOMS(ROOMS)
  ) dut (
    .clk_i               (clk),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_action_i         (in_action_i),
    .in_start_time_i     (in_start_time_i),
    .in_end_time_i       (in_end_time_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_assigned_room_o (out_assigned_room_o),
    .out_finish_time_o   (out_finish_time_o),
    .out_delayed_o       (out_delayed_o),
    .out_busiest_room_o  (out_busiest_room_o),
    .out_busiest_count_o (out_busiest_count_o)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic allocation_t allocate_room(input logic action,
                                                input logic [rba_pkg::TIME_W-1:0] start_t,
                                                input logic [rba_pkg::TIME_W-1:0] end_t);
    allocation_t                  r;
    int                           rooms;
    int                           pick;
    int                           i;
    bit                           found;
    logic [rba_pkg::FINISH_W-1:0] start_w;
    logic [rba_pkg::FINISH_W-1:0] end_w;
    logic [rba_pkg::FINISH_W-1:0] dur;
    logic [rba_pkg::FINISH_W-1:0] base;
    r = '0;
    if (action == rba_pkg::ACT_CLEAR) begin
      for (i = 0; i < ROOMS; i++) begin
        room_free_at[i] = '0;
        room_bookings[i] = '0;
      end
      top_count = '0;
      top_room = '0;
      return r;
    end
    rooms = (rooms_cfg == 0) ? 1 : (rooms_cfg > ROOMS) ? ROOMS : int'(rooms_cfg);
    start_w = {{(rba_pkg::FINISH_W-rba_pkg::TIME_W){1'b0}}, start_t};
    end_w = {{(rba_pkg::FINISH_W-rba_pkg::TIME_W){1'b0}}, end_t};
    found = 1'b0;
    pick = 0;
    for (i = 0; i < rooms; i++) begin
      if (!found && room_free_at[i] <= start_w) begin
        pick = i;
        found = 1'b1;
      end
    end
    if (found) begin
      r.finish = end_w;
    end else begin
      // No room is free: take the earliest finisher and keep the duration.
      dur = (end_w > start_w) ? end_w - start_w : '0;
      pick = 0;
      for (i = 1; i < rooms; i++) begin
        if (room_free_at[i] < room_free_at[pick]) pick = i;
      end
      base = room_free_at[pick];
      r.finish = (dur > rba_pkg::FINISH_MAX - base) ? rba_pkg::FINISH_MAX : base + dur;
      r.delayed = 1'b1;
    end
    room_free_at[pick] = r.finish;
    if (room_bookings[pick] != rba_pkg::COUNT_MAX) room_bookings[pick]++;
    if (room_bookings[pick] > top_count ||
        (room_bookings[pick] == top_count && rba_pkg::ROOM_W'(pick) < top_room)) begin
      top_count = room_bookings[pick];
      top_room = rba_pkg::ROOM_W'(pick);
    end
    r.room = rba_pkg::ROOM_W'(pick);
    r.busiest_room = top_room;
    r.busiest_count = top_count;
    return r;
  endfunction

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < out_idle_pct);
    end
  end

  always @(posedge clk) begin
    allocation_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (allocations.size() == 0) begin
        $error("result with no request outstanding: room %0d finish %0d",
               out_assigned_room_o, out_finish_time_o);
        errors++;
      end else begin
        want = allocations.pop_front();
        if (out_assigned_room_o !== want.room) begin
          $error("assigned_room: expected %0d, got %0d", want.room, out_assigned_room_o);
          errors++;
        end
        if (out_finish_time_o !== want.finish) begin
          $error("finish_time: expected %0d, got %0d", want.finish, out_finish_time_o);
          errors++;
        end
        if (out_delayed_o !== want.delayed) begin
          $error("delayed: expected %0d, got %0d", want.delayed, out_delayed_o);
          errors++;
        end
        if (out_busiest_room_o !== want.busiest_room) begin
          $error("busiest_room: expected %0d, got %0d", want.busiest_room,
                 out_busiest_room_o);
          errors++;
        end
        if (out_busiest_count_o !== want.busiest_count) begin
          $error("busiest_count: expected %0d, got %0d", want.busiest_count,
                 out_busiest_count_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic action,
                              input logic [rba_pkg::TIME_W-1:0] start_t,
                              input logic [rba_pkg::TIME_W-1:0] end_t);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk);
    end
    in_valid_i <= 1'b1;
    in_action_i <= action;
    in_start_time_i <= start_t;
    in_end_time_i <= end_t;
    forever begin
      @(posedge clk);
      if (!in_stall_o) break;
    end
    allocations.push_back(allocate_room(action, start_t, end_t));
  endtask

  task automatic book(input logic [rba_pkg::TIME_W-1:0] start_t,
                      input logic [rba_pkg::TIME_W-1:0] end_t);
    send_request(rba_pkg::ACT_BOOK, start_t, end_t);
  endtask

  task automatic clear_rooms();
    send_request(rba_pkg::ACT_CLEAR, $urandom(), $urandom());
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (allocations.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_room_count(input logic [rba_pkg::CFG_W-1:0] count);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i <= count;
    forever begin
      @(posedge clk);
      if (cfg_ready_o) break;
    end
    cfg_valid_i <= 1'b0;
    rooms_cfg = count;
  endtask

  // Sixteen rooms out of reset: zero and maximum times, end before start,
  // a start that goes backwards, and a clear.
  task automatic test_fresh_rooms();
    book(32'd0, 32'd0);
    book(32'd0, 32'hFFFF_FFFF);
    book(32'd7, 32'd3);
    book(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    book(32'd10, 32'd20);
    clear_rooms();
    book(32'd100, 32'd200);
    wait_idle();
  endtask

  // A count of zero acts as one room, so every overlap is pushed back.
  task automatic test_single_room();
    set_room_count('0);
    clear_rooms();
    book(32'd0, 32'd100);
    book(32'd50, 32'd40);
    book(32'd60, 32'd90);
    book(32'd200, 32'd250);
    set_room_count(5'd1);
    book(32'd0, 32'hFFFF_FFFF);
    wait_idle();
  endtask

  // Rooms above a shrunk count keep their bookings and still count as busiest.
  task automatic test_shrink_count();
    set_room_count(5'd4);
    clear_rooms();
    book(32'd0, 32'd1000);
    book(32'd0, 32'd1000);
    book(32'd0, 32'd1000);
    book(32'd0, 32'd500);
    book(32'd0, 32'd100);
    set_room_count(5'd2);
    book(32'd0, 32'd50);
    wait_idle();
  endtask

  // One room and back-to-back maximum-length meetings push each finish time
  // out by the full duration, well past the 32-bit range.
  task automatic test_delay_chain();
    int n;
    set_room_count(5'd1);
    clear_rooms();
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (n = 0; n < CHAIN_BOOKINGS; n++) book(32'd0, 32'hFFFF_FFFF);
    wait_idle();
    in_idle_pct = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  task automatic test_random_traffic();
    logic [rba_pkg::CFG_W-1:0]  counts [8];
    logic [rba_pkg::TIME_W-1:0] next_start;
    logic [rba_pkg::TIME_W-1:0] s;
    int                         phase;
    int                         n;
    int                         pick;
    counts = '{5'd16, 5'd0, 5'd31, 5'd2, 5'd5, 5'd1, 5'd17, 5'd3};
    counts[7] = rba_pkg::CFG_W'($urandom_range(0, 31));
    for (phase = 0; phase < 8; phase++) begin
      set_room_count(counts[phase]);
      // One phase runs with neither side idling.
      in_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      out_idle_pct = (phase == 3) ? 0 : IDLE_PCT;
      next_start = $urandom();
      for (n = 0; n < PHASE_ITEMS; n++) begin
        pick = $urandom_range(99);
        if (pick < 3) begin
          clear_rooms();
          next_start = $urandom();
        end else if (pick < 10) begin
          book($urandom(), $urandom());
        end else if (pick < 14) begin
          s = $urandom();
          book(s, s - $urandom_range(0, 50));
        end else begin
          next_start += $urandom_range(0, 8);
          book(next_start, next_start + $urandom_range(1, 120));
        end
      end
    end
    wait_idle();
    in_idle_pct = IDLE_PCT;
    out_idle_pct = IDLE_PCT;
  endtask

  // The receiver holds off while requests keep coming, so the block backs up.
  task automatic test_output_backpressure();
    logic [rba_pkg::TIME_W-1:0] s;
    int                         n;
    set_room_count(5'd3);
    clear_rooms();
    hold_req <= hold_req + 1;
    s = $urandom_range(0, 1000);
    for (n = 0; n < 30; n++) begin
      s += $urandom_range(0, 5);
      book(s, s + $urandom_range(1, 40));
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);
    test_fresh_rooms();
    test_single_room();
    test_shrink_count();
    test_output_backpressure();
    test_random_traffic();
    test_delay_chain();
    set_room_count(rba_pkg::ROOMS_RESET);
    wait_idle();
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
design/rba_pkg.sv
design/rba_ctrl.sv
design/rba_datapath.sv
design/room_booking_allocator_core.sv
design/rba_checker.sv
test/testbench.sv
